// ----- hdl/cgts_pkg.sv -----
// Shared constants, codes and types for the column gap text segmenter.
// No dependencies; imported by every module of the block.
package cgts_pkg;

    localparam int PIX_W       = 8;
    localparam int BND_W       = 13;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int END_MARGIN  = 3;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd250;
    localparam logic [BND_W-1:0] WIDTH_RST     = 13'd1024;
    localparam logic [BND_W-1:0] HEIGHT_RST    = 13'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 8'd2;

    // Classification of a completed column, handed from front to back.
    typedef struct packed {
        logic white;
        logic last;
    } t_col_flags;

endpackage

// ----- hdl/cgts_front.sv -----
// Front part: accepts pixels, counts rows and columns and classifies each column.
// Depends on cgts_pkg; feeds one record per completed column into cgts_queue.
module cgts_front
    import cgts_pkg::*;
#(
    parameter int COL_W = 12,
    parameter int ROW_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [PIX_W-1:0] i_pixel_value,
    input  logic [PIX_W-1:0] i_threshold,
    input  logic [BND_W-1:0] i_width,
    input  logic [BND_W-1:0] i_height,
    output logic             o_push,
    output t_col_flags       o_flags,
    output logic [COL_W-1:0] o_col
);

    localparam int RCMP_W = (ROW_W > BND_W ? ROW_W : BND_W) + 1;
    localparam int CCMP_W = (COL_W > BND_W ? COL_W : BND_W) + 1;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_all_white, n_all_white;
    logic             white_now;
    logic             col_end;
    logic             img_end;

    always_comb begin
        white_now = r_all_white & (i_pixel_value >= i_threshold);
        // A column ends once the row count reaches the height, even if the
        // height was lowered part way through a column.
        col_end = (RCMP_W'(r_row) + RCMP_W'(1)) >= RCMP_W'(i_height);
        img_end = (CCMP_W'(r_col) + CCMP_W'(1)) >= CCMP_W'(i_width);

        n_row       = r_row;
        n_col       = r_col;
        n_all_white = r_all_white;
        if (i_take) begin
            if (col_end) begin
                n_row       = '0;
                n_all_white = 1'b1;
                n_col       = img_end ? '0 : r_col + COL_W'(1);
            end else begin
                n_row       = r_row + ROW_W'(1);
                n_all_white = white_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_all_white <= 1'b1;
        end else begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_all_white <= n_all_white;
        end
    end

    assign o_push        = i_take & col_end;
    assign o_flags.white = white_now;
    assign o_flags.last  = img_end;
    assign o_col         = r_col;

endmodule

// ----- hdl/cgts_queue.sv -----
// Short first-in first-out queue of column records between front and back.
// Depends on cgts_pkg for the default depth.
module cgts_queue
    import cgts_pkg::*;
#(
    parameter int W     = 27,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

endmodule

// ----- hdl/cgts_back.sv -----
// Back part: tracks blank-column runs and produces boundary words.
// Depends on cgts_pkg; takes column records from cgts_queue.
module cgts_back
    import cgts_pkg::*;
#(
    parameter int COL_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_col_flags       i_flags,
    input  logic [COL_W-1:0] i_col,
    input  logic [BND_W-1:0] i_width,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [BND_W-1:0] o_boundary_column,
    output logic             o_is_final
);

    localparam int SUM_W = COL_W + 1;
    localparam int MRG_W = BND_W + 1;

    logic             r_inside, n_inside;
    logic             r_has, n_has;
    logic [COL_W-1:0] r_first, n_first;

    logic             r_out_valid, n_out_valid;
    logic [BND_W-1:0] r_out_col, n_out_col;
    logic             r_out_fin, n_out_fin;
    logic             r_pend_valid, n_pend_valid;
    logic [BND_W-1:0] r_pend_col, n_pend_col;

    logic             out_free;
    logic             emit_end;
    logic [SUM_W-1:0] sum_end;
    logic [SUM_W-1:0] sum_last;
    logic [COL_W-1:0] first_eff;
    logic [BND_W-1:0] end_mid;
    logic [BND_W-1:0] last_val;
    logic [BND_W-1:0] val0;
    logic             tail_ok;
    logic             any_out;
    logic             two_out;

    always_comb begin
        out_free = ~r_out_valid | ~i_stall;
        o_pop    = ~i_empty & ~r_pend_valid & out_free;

        // A dark column closes an open run; with no blank column recorded
        // (dark first column) the boundary is column zero.
        emit_end = r_inside & ~i_flags.white;
        sum_end  = SUM_W'(r_first) + SUM_W'(i_col) - SUM_W'(1);
        end_mid  = r_has ? BND_W'(sum_end >> 1) : '0;

        first_eff = r_has ? r_first : i_col;
        sum_last  = SUM_W'(first_eff) + SUM_W'(i_col);
        last_val  = (r_inside & i_flags.white) ? BND_W'(sum_last >> 1) : i_width;
        tail_ok   = (MRG_W'(last_val) + MRG_W'(END_MARGIN)) < MRG_W'(i_width);

        val0    = emit_end ? end_mid : last_val;
        any_out = emit_end | i_flags.last;
        two_out = i_flags.last & (emit_end | tail_ok);

        n_inside = r_inside;
        n_has    = r_has;
        n_first  = r_first;
        if (o_pop) begin
            if (i_flags.last) begin
                n_inside = 1'b1;
                n_has    = 1'b0;
                n_first  = '0;
            end else begin
                if (i_flags.white && !r_has) begin
                    n_first = i_col;
                    n_has   = 1'b1;
                end
                if (emit_end) begin
                    n_inside = 1'b0;
                    n_has    = 1'b0;
                end
                if (i_flags.white) begin
                    n_inside = 1'b1;
                end
            end
        end

        n_out_valid  = r_out_valid;
        n_out_col    = r_out_col;
        n_out_fin    = r_out_fin;
        n_pend_valid = r_pend_valid;
        n_pend_col   = r_pend_col;
        if (out_free) begin
            if (r_pend_valid) begin
                // The second word of a column is always the image width.
                n_out_valid  = 1'b1;
                n_out_col    = r_pend_col;
                n_out_fin    = 1'b1;
                n_pend_valid = 1'b0;
            end else if (o_pop && any_out) begin
                n_out_valid  = 1'b1;
                n_out_col    = val0;
                n_out_fin    = i_flags.last & ~two_out;
                n_pend_valid = two_out;
                n_pend_col   = i_width;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b1;
            r_has        <= 1'b0;
            r_first      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_inside     <= n_inside;
            r_has        <= n_has;
            r_first      <= n_first;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_col  <= n_out_col;
        r_out_fin  <= n_out_fin;
        r_pend_col <= n_pend_col;
    end

    assign o_valid           = r_out_valid;
    assign o_boundary_column = r_out_col;
    assign o_is_final        = r_out_fin;

endmodule

// ----- hdl/column_gap_text_segmenter_unit.sv -----
// Channel   Direction  Handshake            Payload
// pixel     in         valid / stall        pixel_value (8)
// boundary  out        valid / stall        boundary_column (13), is_final (1)
// cfg       in         valid / ready        cfg_index (8), cfg_data (13)
//
// One pixel is taken per cycle while the queue is not full; a completed column goes as a
// record through a four-entry queue to the back part, which takes no record while a
// second boundary word is pending, so the single output register sets the limit.
// Pixel stall is raised only while the queue is full, and an output stall backs up
// into the queue first. Reset is synchronous and active low; it restores the
// register defaults and starts a new image with no clearing pass.
// Depends on cgts_pkg, cgts_front, cgts_queue and cgts_back.
module column_gap_text_segmenter_unit
    import cgts_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pixel_valid,
    output logic                  o_pixel_stall,
    input  logic [PIX_W-1:0]      i_pixel_value,
    output logic                  o_boundary_valid,
    input  logic                  i_boundary_stall,
    output logic [BND_W-1:0]      o_boundary_column,
    output logic                  o_is_final,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
    localparam int REC_W = $bits(t_col_flags) + COL_W + BND_W;

    logic [PIX_W-1:0] r_threshold;
    logic [BND_W-1:0] r_width_cfg;
    logic [BND_W-1:0] r_height_cfg;
    logic [BND_W-1:0] width_eff;
    logic [BND_W-1:0] height_eff;

    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             push;
    t_col_flags       push_flags;
    logic [COL_W-1:0] push_col;
    logic [REC_W-1:0] head;
    t_col_flags       head_flags;
    logic [COL_W-1:0] head_col;
    logic [BND_W-1:0] head_width;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_width_cfg  <= WIDTH_RST;
            r_height_cfg <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WHITE_THRESHOLD: r_threshold  <= i_cfg_data[PIX_W-1:0];
                CFG_IMAGE_WIDTH:     r_width_cfg  <= i_cfg_data;
                CFG_IMAGE_HEIGHT:    r_height_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sizes outside the supported range are pulled into it.
    always_comb begin
        if (r_width_cfg == '0) begin
            width_eff = BND_W'(1);
        end else if (int'(r_width_cfg) > MAX_WIDTH) begin
            width_eff = BND_W'(MAX_WIDTH);
        end else begin
            width_eff = r_width_cfg;
        end
        if (r_height_cfg == '0) begin
            height_eff = BND_W'(1);
        end else if (int'(r_height_cfg) > MAX_HEIGHT) begin
            height_eff = BND_W'(MAX_HEIGHT);
        end else begin
            height_eff = r_height_cfg;
        end
    end

    assign o_pixel_stall = q_full;

    cgts_front #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (i_pixel_valid & ~q_full),
        .i_pixel_value (i_pixel_value),
        .i_threshold   (r_threshold),
        .i_width       (width_eff),
        .i_height      (height_eff),
        .o_push        (push),
        .o_flags       (push_flags),
        .o_col         (push_col)
    );

    cgts_queue #(
        .W     (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_flags, push_col, width_eff}),
        .i_pop   (q_pop),
        .o_data  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {head_flags, head_col, head_width} = head;

    cgts_back #(
        .COL_W (COL_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (q_empty),
        .i_flags           (head_flags),
        .i_col             (head_col),
        .i_width           (head_width),
        .o_pop             (q_pop),
        .o_valid           (o_boundary_valid),
        .i_stall           (i_boundary_stall),
        .o_boundary_column (o_boundary_column),
        .o_is_final        (o_is_final)
    );

endmodule
